/* rtl/core/bwi_pkg.sv */
// Shared types, codes and widths for the breakpoint waveform interpolator.
package bwi_pkg;

   localparam int LEVEL_W     = 14;
   localparam int POS_W       = 13;
   localparam int OP_W        = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int QUO_W       = 16;
   localparam int DEF_SAMPLES = 8192;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_SET    = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_W-1:0] OP_READ   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_LEVEL = 2'd1;

   localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 14'h3FFF;
   localparam logic [LEVEL_W-1:0] MID_LEVEL_RST = 14'h2000;

   localparam logic [1:0] RD_POS = 2'd0;
   localparam logic [1:0] RD_P1  = 2'd1;
   localparam logic [1:0] RD_P2  = 2'd2;

   typedef struct packed {
      logic       load;
      logic       clr_step;
      logic       wr_pos;
      logic       unmark;
      logic       scan_left_start;
      logic       scan_right_start;
      logic       p1_from_pos;
      logic       p2_from_pos;
      logic       scan_step;
      logic [1:0] rd_sel;
      logic       cap_d1;
      logic       cap_d2;
      logic       div_start;
      logic       fill_init;
      logic       fill_step;
      logic       rsp_load;
      logic       rsp_status;
      logic       rsp_use_rd;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            pos_oob;
      logic            pos_first;
      logic            pos_last;
      logic            bp_hit;
      logic            scan_found;
      logic            seg_short;
      logic            div_done;
      logic            fill_last;
      logic            clr_last;
   } stat_type;

endpackage

/* rtl/core/bwi_div.sv */
// Restoring divider, one quotient bit per cycle, for the ramp step.
module bwi_div #(
   parameter int DW = 14
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [bwi_pkg::QUO_W-1:0] dividend,
   input  logic [DW-1:0]            divisor,
   output logic [bwi_pkg::QUO_W-1:0] quo,
   output logic [DW-1:0]            rem,
   output logic                     done
);
   import bwi_pkg::*;

   localparam int CW = $clog2(QUO_W + 1);

   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    dsr_ff, dsr_in;
   logic [DW:0]      trial;
   logic             fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[QUO_W-1]};
      fits   = trial >= {1'b0, dsr_ff};
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      if (start) begin
         cnt_in = CW'(QUO_W);
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         quo_in = {quo_ff[QUO_W-2:0], fits};
         rem_in = fits ? DW'(trial - {1'b0, dsr_ff}) : trial[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quo  = quo_ff;
   assign rem  = rem_ff;
   assign done = (cnt_ff == '0) && !start;

endmodule

/* rtl/core/bwi_dpath.sv */
// Datapath: sample and breakpoint memories, scan, ramp generator and result register.
module bwi_dpath #(
   parameter int SAMPLES = bwi_pkg::DEF_SAMPLES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bwi_pkg::cmd_type             cmd,
   output bwi_pkg::stat_type            stat,
   input  logic [bwi_pkg::OP_W-1:0]     req_op,
   input  logic [bwi_pkg::POS_W-1:0]    req_position,
   input  logic [bwi_pkg::LEVEL_W-1:0]  req_level,
   input  logic                         csr_write_en,
   input  logic [bwi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bwi_pkg::LEVEL_W-1:0]  csr_wdata,
   output logic [bwi_pkg::LEVEL_W-1:0]  rsp_read_level,
   output logic                         rsp_status
);
   import bwi_pkg::*;

   localparam int AW = $clog2(SAMPLES);
   localparam int DW = AW + 1;
   localparam logic [AW-1:0] LAST = AW'(SAMPLES - 1);

   logic [LEVEL_W-1:0] samp_mem [SAMPLES];
   logic               bp_mem   [SAMPLES];

   logic [LEVEL_W-1:0] max_level_ff, mid_level_ff;
   logic [OP_W-1:0]    op_ff;
   logic [AW-1:0]      pos_ff;
   logic [LEVEL_W-1:0] lvl_ff;
   logic               oob_ff;
   logic [AW-1:0]      clr_addr_ff;
   logic [AW-1:0]      scan_addr_ff;
   logic               scan_left_ff;
   logic               chk_valid_ff;
   logic [AW-1:0]      chk_addr_ff;
   logic [AW-1:0]      p1_ff, p2_ff;
   logic [LEVEL_W-1:0] d1_ff, d2_ff;
   logic signed [16:0] dq_ff, q_ff;
   logic [DW-1:0]      dr_ff, den2_ff, r_ff;
   logic [AW-1:0]      fill_i_ff;
   logic [LEVEL_W-1:0] samp_rd_ff, rd_level_ff;
   logic               bp_rd_ff, status_ff;

   logic               samp_we, bp_we, bp_wdata;
   logic [AW-1:0]      samp_waddr, samp_raddr, bp_waddr, bp_raddr;
   logic [LEVEL_W-1:0] samp_wdata;
   logic [AW-1:0]      den;
   logic [DW-1:0]      den2;
   logic               neg;
   logic [LEVEL_W-1:0] mag;
   logic [QUO_W-1:0]   div_quo;
   logic [DW-1:0]      div_rem;
   logic               div_done;
   logic               rem_nz;
   logic signed [16:0] dq_in, q_next;
   logic [DW-1:0]      dr_in, r_next;
   logic [DW:0]        r_sum;
   logic               carry;
   logic [LEVEL_W-1:0] lvl_in;

   assign den    = p2_ff - p1_ff;
   assign den2   = {den, 1'b0};
   assign neg    = d2_ff < d1_ff;
   assign mag    = neg ? (d1_ff - d2_ff) : (d2_ff - d1_ff);
   assign rem_nz = div_rem != '0;
   assign lvl_in = (req_level > max_level_ff) ? max_level_ff : req_level;

   bwi_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({1'b0, mag, 1'b0}),
      .divisor  (den2),
      .quo      (div_quo),
      .rem      (div_rem),
      .done     (div_done)
   );

   always_comb begin
      dq_in = $signed({1'b0, div_quo});
      dr_in = div_rem;
      if (neg) begin
         dq_in = -($signed({1'b0, div_quo}) + $signed({16'd0, rem_nz}));
         dr_in = rem_nz ? (den2 - div_rem) : '0;
      end
      r_sum  = {1'b0, r_ff} + {1'b0, dr_ff};
      carry  = r_sum >= {1'b0, den2_ff};
      r_next = carry ? DW'(r_sum - {1'b0, den2_ff}) : r_sum[DW-1:0];
      q_next = q_ff + dq_ff + $signed({16'd0, carry});
   end

   // memory port steering
   always_comb begin
      samp_we  = cmd.clr_step || cmd.wr_pos || cmd.fill_step;
      bp_we    = cmd.clr_step || cmd.wr_pos || cmd.unmark;
      priority if (cmd.clr_step) begin
         samp_waddr = clr_addr_ff;
         samp_wdata = mid_level_ff;
         bp_waddr   = clr_addr_ff;
         bp_wdata   = (clr_addr_ff == '0) || (clr_addr_ff == LAST);
      end else if (cmd.wr_pos || cmd.unmark) begin
         samp_waddr = pos_ff;
         samp_wdata = lvl_ff;
         bp_waddr   = pos_ff;
         bp_wdata   = cmd.wr_pos;
      end else begin
         samp_waddr = fill_i_ff;
         samp_wdata = q_next[LEVEL_W-1:0];
         bp_waddr   = pos_ff;
         bp_wdata   = 1'b0;
      end
      unique case (cmd.rd_sel)
         RD_P1:   samp_raddr = p1_ff;
         RD_P2:   samp_raddr = p2_ff;
         default: samp_raddr = pos_ff;
      endcase
      bp_raddr = cmd.scan_step ? scan_addr_ff : pos_ff;
   end

   always_ff @(posedge clock) begin
      if (samp_we) begin
         samp_mem[samp_waddr] <= samp_wdata;
      end
      samp_rd_ff <= samp_mem[samp_raddr];
   end

   always_ff @(posedge clock) begin
      if (bp_we) begin
         bp_mem[bp_waddr] <= bp_wdata;
      end
      bp_rd_ff <= bp_mem[bp_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_level_ff <= MAX_LEVEL_RST;
         mid_level_ff <= MID_LEVEL_RST;
         clr_addr_ff  <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en && (csr_index == CSR_MAX_LEVEL)) begin
            max_level_ff <= csr_wdata;
         end
         if (csr_write_en && (csr_index == CSR_MID_LEVEL)) begin
            mid_level_ff <= csr_wdata;
         end
         if (cmd.clr_step) begin
            clr_addr_ff <= (clr_addr_ff == LAST) ? '0 : clr_addr_ff + 1'b1;
         end
         if (cmd.scan_left_start || cmd.scan_right_start) begin
            chk_valid_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            chk_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         pos_ff <= AW'(req_position);
         lvl_ff <= lvl_in;
         oob_ff <= 32'(req_position) >= 32'(SAMPLES);
      end
      if (cmd.scan_step && chk_valid_ff && bp_rd_ff) begin
         if (scan_left_ff) begin
            p1_ff <= chk_addr_ff;
         end else begin
            p2_ff <= chk_addr_ff;
         end
      end
      if (cmd.p1_from_pos) begin
         p1_ff <= pos_ff;
      end
      if (cmd.p2_from_pos) begin
         p2_ff <= pos_ff;
      end
      if (cmd.scan_left_start) begin
         scan_addr_ff <= pos_ff - 1'b1;
         scan_left_ff <= 1'b1;
      end else if (cmd.scan_right_start) begin
         scan_addr_ff <= pos_ff + 1'b1;
         scan_left_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         scan_addr_ff <= scan_left_ff ? scan_addr_ff - 1'b1 : scan_addr_ff + 1'b1;
      end
      if (cmd.scan_step) begin
         chk_addr_ff <= scan_addr_ff;
      end
      if (cmd.cap_d1) begin
         d1_ff <= samp_rd_ff;
      end
      if (cmd.cap_d2) begin
         d2_ff <= samp_rd_ff;
      end
      if (cmd.fill_init) begin
         dq_ff     <= dq_in;
         dr_ff     <= dr_in;
         den2_ff   <= den2;
         q_ff      <= $signed({3'd0, d1_ff});
         r_ff      <= {1'b0, den};
         fill_i_ff <= p1_ff + 1'b1;
      end else if (cmd.fill_step) begin
         q_ff      <= q_next;
         r_ff      <= r_next;
         fill_i_ff <= fill_i_ff + 1'b1;
      end
      if (cmd.rsp_load) begin
         rd_level_ff <= cmd.rsp_use_rd ? samp_rd_ff : '0;
         status_ff   <= cmd.rsp_status;
      end
   end

   always_comb begin
      stat            = '0;
      stat.op         = op_ff;
      stat.pos_oob    = oob_ff;
      stat.pos_first  = pos_ff == '0;
      stat.pos_last   = pos_ff == LAST;
      stat.bp_hit     = bp_rd_ff;
      stat.scan_found = chk_valid_ff && bp_rd_ff;
      stat.seg_short  = {1'b0, p2_ff} <= ({1'b0, p1_ff} + 1'b1);
      stat.div_done   = div_done;
      stat.fill_last  = fill_i_ff == (p2_ff - 1'b1);
      stat.clr_last   = clr_addr_ff == LAST;
   end

   assign rsp_read_level = rd_level_ff;
   assign rsp_status     = status_ff;

   a_fill_inside: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_step |-> (fill_i_ff > p1_ff) && (fill_i_ff < p2_ff))
      else $error("ramp write outside its segment");

   a_fill_level: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_step |-> (q_next >= 17'sd0) && (q_next <= 17'sd16383))
      else $error("ramp level out of range");

   a_fill_rem: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_step |-> r_ff < den2_ff)
      else $error("ramp remainder not below divisor");

endmodule

/* rtl/core/bwi_ctrl.sv */
// Controller state machine sequencing clear, set, remove and read.
module bwi_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  bwi_pkg::stat_type stat,
   output bwi_pkg::cmd_type  cmd
);
   import bwi_pkg::*;

   localparam logic [3:0] ST_CLR    = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_CHK    = 4'd2;
   localparam logic [3:0] ST_RMCHK  = 4'd3;
   localparam logic [3:0] ST_SETW   = 4'd4;
   localparam logic [3:0] ST_SCAN   = 4'd5;
   localparam logic [3:0] ST_SEGCHK = 4'd6;
   localparam logic [3:0] ST_RD1    = 4'd7;
   localparam logic [3:0] ST_RD2    = 4'd8;
   localparam logic [3:0] ST_RD3    = 4'd9;
   localparam logic [3:0] ST_DIVS   = 4'd10;
   localparam logic [3:0] ST_DIVW   = 4'd11;
   localparam logic [3:0] ST_FILL   = 4'd12;
   localparam logic [3:0] ST_DONE   = 4'd13;

   localparam logic [1:0] PH_SETL = 2'd0;
   localparam logic [1:0] PH_SETR = 2'd1;
   localparam logic [1:0] PH_RML  = 2'd2;
   localparam logic [1:0] PH_RMR  = 2'd3;

   logic [3:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       from_op_ff, from_op_in;
   logic       status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       seg_done;

   always_comb begin
      cmd          = '0;
      cmd.rd_sel   = RD_POS;
      state_in     = state_ff;
      phase_in     = phase_ff;
      from_op_in   = from_op_ff;
      status_in    = status_ff;
      seg_done     = 1'b0;
      unique case (state_ff)
         ST_CLR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = from_op_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load  = 1'b1;
               status_in = 1'b0;
               state_in  = ST_CHK;
            end
         end
         ST_CHK: begin
            priority if (stat.op == OP_CLEAR) begin
               from_op_in = 1'b1;
               state_in   = ST_CLR;
            end else if (stat.pos_oob) begin
               status_in = 1'b1;
               state_in  = ST_DONE;
            end else if (stat.op == OP_SET) begin
               state_in = ST_SETW;
            end else if (stat.op == OP_REMOVE) begin
               if (stat.pos_first || stat.pos_last) begin
                  status_in = 1'b1;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_RMCHK;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RMCHK: begin
            if (stat.bp_hit) begin
               cmd.unmark          = 1'b1;
               cmd.scan_left_start = 1'b1;
               phase_in            = PH_RML;
               state_in            = ST_SCAN;
            end else begin
               status_in = 1'b1;
               state_in  = ST_DONE;
            end
         end
         ST_SETW: begin
            cmd.wr_pos = 1'b1;
            if (!stat.pos_first) begin
               cmd.scan_left_start = 1'b1;
               cmd.p2_from_pos     = 1'b1;
               phase_in            = PH_SETL;
               state_in            = ST_SCAN;
            end else begin
               cmd.scan_right_start = 1'b1;
               cmd.p1_from_pos      = 1'b1;
               phase_in             = PH_SETR;
               state_in             = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_found) begin
               if (phase_ff == PH_RML) begin
                  cmd.scan_right_start = 1'b1;
                  phase_in             = PH_RMR;
               end else begin
                  state_in = ST_SEGCHK;
               end
            end
         end
         ST_SEGCHK: begin
            cmd.rd_sel = RD_P1;
            if (stat.seg_short) begin
               seg_done = 1'b1;
            end else begin
               state_in = ST_RD1;
            end
         end
         ST_RD1: begin
            cmd.rd_sel = RD_P1;
            state_in   = ST_RD2;
         end
         ST_RD2: begin
            cmd.rd_sel = RD_P2;
            cmd.cap_d1 = 1'b1;
            state_in   = ST_RD3;
         end
         ST_RD3: begin
            cmd.cap_d2 = 1'b1;
            state_in   = ST_DIVS;
         end
         ST_DIVS: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVW;
         end
         ST_DIVW: begin
            if (stat.div_done) begin
               cmd.fill_init = 1'b1;
               state_in      = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (stat.fill_last) begin
               seg_done = 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = status_ff;
               cmd.rsp_use_rd = (stat.op == OP_READ) && !status_ff;
               from_op_in     = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // after a segment: set still has its right segment unless at the far end
      if (seg_done) begin
         if ((phase_ff == PH_SETL) && !stat.pos_last) begin
            cmd.scan_right_start = 1'b1;
            cmd.p1_from_pos      = 1'b1;
            phase_in             = PH_SETR;
            state_in             = ST_SCAN;
         end else begin
            state_in = ST_DONE;
         end
      end
      rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         phase_ff     <= PH_SETL;
         from_op_ff   <= 1'b0;
         status_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         from_op_ff   <= from_op_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_ready)
      else $error("second transfer taken before the first finished");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before its transfer");

   a_scan_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.fill_step && (cmd.scan_step || cmd.clr_step || cmd.wr_pos)))
      else $error("conflicting memory commands");

endmodule

/* rtl/core/breakpoint_waveform_interpolator_top.sv */
// Top level: breakpoint waveform interpolator, controller plus datapath.
// Read and ignored ops go straight to the result; remove first checks the point's mark.
// Clear sweeps all SAMPLES entries. Set/remove: scan to each neighbouring breakpoint,
// then refill each segment's inner points with a ramp whose step comes from the divider.
// One operation in flight; next transfer accepted in the cycle after the result is loaded.
// Reset: sweeps all SAMPLES entries (mid level, end breakpoints) with req_ready low.
module breakpoint_waveform_interpolator_top #(
   parameter int SAMPLES = bwi_pkg::DEF_SAMPLES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bwi_pkg::OP_W-1:0]      req_op,
   input  logic [bwi_pkg::POS_W-1:0]     req_position,
   input  logic [bwi_pkg::LEVEL_W-1:0]   req_level,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bwi_pkg::LEVEL_W-1:0]   rsp_read_level,
   output logic                          rsp_status,
   input  logic                          csr_write_en,
   input  logic [bwi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bwi_pkg::LEVEL_W-1:0]   csr_wdata
);
   import bwi_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bwi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bwi_dpath #(.SAMPLES(SAMPLES)) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req_op),
      .req_position   (req_position),
      .req_level      (req_level),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_read_level (rsp_read_level),
      .rsp_status     (rsp_status)
   );

endmodule
